@@ hdl/md5_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the MD5 hash core.
// Used by md5_front, md5_fifo, md5_back and md5_hash_core_top.
package md5_pkg;

    localparam logic [31:0] INIT_A   = 32'h67452301;
    localparam logic [31:0] INIT_B   = 32'hefcdab89;
    localparam logic [31:0] INIT_C   = 32'h98badcfe;
    localparam logic [31:0] INIT_D   = 32'h10325476;
    localparam logic [31:0] PAD_WORD = 32'h00000080;

    // Word slots of the bit count inside the final block, and the last word slot of a block.
    localparam logic [3:0] LEN_LO_SLOT = 4'd14;
    localparam logic [3:0] LEN_HI_SLOT = 4'd15;
    localparam logic [3:0] LAST_SLOT   = 4'd15;

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // One classified message word, already masked and marked when it is the last one.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;    // 0 to 4
        logic        last;
        logic        mark_next; // padding byte 0x80 still owed in the next word
    } t_entry;

    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    function automatic logic [4:0] rot_amt(input logic [1:0] rnd, input logic [1:0] j);
        logic [4:0] s;
        unique case ({rnd, j})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

endpackage

@@ hdl/md5_front.sv @@
`timescale 1ns / 1ps
// Input stage: takes message words, classifies them and applies the
// last-word byte mask and padding mark. Depends on md5_pkg.
module md5_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_message_word,
    input  logic [2:0]         i_valid_bytes,
    input  logic               i_is_last,
    output logic               o_push,
    output md5_pkg::t_entry    o_entry,
    input  logic               i_full
);
    import md5_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    t_entry n_entry;
    logic   accept;

    assign o_stall = r_valid & i_full;
    assign accept  = i_valid & ~o_stall;
    assign o_push  = r_valid & ~i_full;
    assign o_entry = r_entry;

    always_comb begin
        n_entry.word      = i_message_word;
        n_entry.nbytes    = 3'd4;
        n_entry.last      = i_is_last;
        n_entry.mark_next = 1'b0;
        if (i_is_last) begin
            // Unused bytes are dropped and the 0x80 mark follows the last byte.
            unique case (i_valid_bytes)
                3'd0: begin
                    n_entry.word   = PAD_WORD;
                    n_entry.nbytes = 3'd0;
                end
                3'd1: begin
                    n_entry.word   = {16'h0000, 8'h80, i_message_word[7:0]};
                    n_entry.nbytes = 3'd1;
                end
                3'd2: begin
                    n_entry.word   = {8'h00, 8'h80, i_message_word[15:0]};
                    n_entry.nbytes = 3'd2;
                end
                3'd3: begin
                    n_entry.word   = {8'h80, i_message_word[23:0]};
                    n_entry.nbytes = 3'd3;
                end
                default: begin
                    n_entry.mark_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept | (r_valid & i_full);
        end
        if (accept) begin
            r_entry <= n_entry;
        end
    end

endmodule

@@ hdl/md5_fifo.sv @@
`timescale 1ns / 1ps
// Short request queue between the front and the back of the MD5 core.
// Depends on md5_pkg for the entry type and depth.
module md5_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  md5_pkg::t_entry    i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output md5_pkg::t_entry    o_entry
);
    import md5_pkg::*;

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

@@ hdl/md5_back.sv @@
`timescale 1ns / 1ps
// Block engine: fills the 16-word block, pads the final block, runs the
// 64-step compression one step per cycle and delivers the digest. Depends on md5_pkg.
module md5_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  md5_pkg::t_entry    i_q_entry,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_digest_word,
    output logic [1:0]         o_word_index,
    output logic               o_digest_done
);
    import md5_pkg::*;

    localparam logic [2:0] S_FILL = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_COMP = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]  r_state;
    logic [3:0]  r_wptr;
    logic [5:0]  r_step;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_chain [4];
    logic [31:0] r_buf [16];
    logic [63:0] r_len;
    logic        r_mark;
    logic        r_len_ok;
    logic        r_pad;
    logic        r_final;
    logic [1:0]  r_oidx;

    logic        wen;
    logic [31:0] wdata;
    logic [1:0]  rnd;
    logic [3:0]  g;
    logic [31:0] f;
    logic [31:0] sum;
    logic [31:0] new_b;
    logic [31:0] pad_data;

    assign o_pop         = i_q_valid & (r_state == S_FILL);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_chain[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_digest_done = (r_oidx == 2'd3);

    // Round function and message word index for the current step.
    always_comb begin
        rnd = r_step[5:4];
        unique case (rnd)
            2'd0: begin
                f = (r_b & r_c) | (~r_b & r_d);
                g = r_step[3:0];
            end
            2'd1: begin
                f = (r_b & r_d) | (r_c & ~r_d);
                g = 4'((r_step[3:0] << 2) + r_step[3:0] + 4'd1);
            end
            2'd2: begin
                f = r_b ^ r_c ^ r_d;
                g = 4'((r_step[3:0] << 1) + r_step[3:0] + 4'd5);
            end
            default: begin
                f = r_c ^ (r_b | ~r_d);
                g = 4'((r_step[3:0] << 3) - r_step[3:0]);
            end
        endcase
        sum   = r_a + f + K_TAB[r_step] + r_buf[g];
        new_b = r_b + rotl32(sum, rot_amt(rnd, r_step[1:0]));
    end

    always_comb begin
        if (r_mark) begin
            pad_data = PAD_WORD;
        end else if (r_len_ok && r_wptr == LEN_LO_SLOT) begin
            pad_data = r_len[31:0];
        end else if (r_len_ok && r_wptr == LEN_HI_SLOT) begin
            pad_data = r_len[63:32];
        end else begin
            pad_data = '0;
        end
        wen   = o_pop | (r_state == S_PAD);
        wdata = (r_state == S_PAD) ? pad_data : i_q_entry.word;
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_buf[r_wptr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FILL;
            r_wptr     <= '0;
            r_step     <= '0;
            r_chain[0] <= INIT_A;
            r_chain[1] <= INIT_B;
            r_chain[2] <= INIT_C;
            r_chain[3] <= INIT_D;
            r_len      <= '0;
            r_mark     <= 1'b0;
            r_len_ok   <= 1'b0;
            r_pad      <= 1'b0;
            r_final    <= 1'b0;
            r_oidx     <= '0;
        end else begin
            unique case (r_state)
                S_FILL: begin
                    if (o_pop) begin
                        r_wptr <= r_wptr + 1'b1;
                        r_len  <= r_len + {58'd0, i_q_entry.nbytes, 3'd0};
                        if (i_q_entry.last) begin
                            r_pad    <= 1'b1;
                            r_final  <= 1'b0;
                            r_mark   <= i_q_entry.mark_next;
                            // The count fits in this block only if the mark lands below slot 14.
                            r_len_ok <= ~i_q_entry.mark_next & (r_wptr < LEN_LO_SLOT);
                        end
                        if (r_wptr == LAST_SLOT) begin
                            r_state <= S_COMP;
                        end else if (i_q_entry.last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_wptr <= r_wptr + 1'b1;
                    if (r_mark) begin
                        r_mark   <= 1'b0;
                        r_len_ok <= (r_wptr < LEN_LO_SLOT);
                    end
                    if (r_wptr == LAST_SLOT) begin
                        r_final <= r_len_ok & ~r_mark;
                        r_state <= S_COMP;
                    end
                end
                S_COMP: begin
                    r_step <= r_step + 1'b1;
                    r_a    <= r_d;
                    r_b    <= new_b;
                    r_c    <= r_b;
                    r_d    <= r_c;
                    if (r_step == 6'd63) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_chain[0] <= r_chain[0] + r_a;
                    r_chain[1] <= r_chain[1] + r_b;
                    r_chain[2] <= r_chain[2] + r_c;
                    r_chain[3] <= r_chain[3] + r_d;
                    if (!r_pad) begin
                        r_state <= S_FILL;
                    end else if (r_final) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        // Padding spilled into a second block: it carries the count.
                        r_len_ok <= 1'b1;
                        r_state  <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_oidx <= r_oidx + 1'b1;
                        if (r_oidx == 2'd3) begin
                            r_chain[0] <= INIT_A;
                            r_chain[1] <= INIT_B;
                            r_chain[2] <= INIT_C;
                            r_chain[3] <= INIT_D;
                            r_len      <= '0;
                            r_wptr     <= '0;
                            r_pad      <= 1'b0;
                            r_final    <= 1'b0;
                            r_len_ok   <= 1'b0;
                            r_state    <= S_FILL;
                        end
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
        end
        // Load the working words as the compression starts.
        if (i_rst_n && ((r_state == S_FILL && o_pop && r_wptr == LAST_SLOT) ||
                        (r_state == S_PAD && r_wptr == LAST_SLOT))) begin
            r_a    <= r_chain[0];
            r_b    <= r_chain[1];
            r_c    <= r_chain[2];
            r_d    <= r_chain[3];
            r_step <= '0;
        end
    end

endmodule

@@ hdl/md5_hash_core_top.sv @@
`timescale 1ns / 1ps
// Top level of the MD5 hash core: input stage, request queue and block engine.
// Depends on md5_pkg, md5_front, md5_fifo and md5_back.

// The core hashes a message given as 32-bit little-endian words, first byte in
// bits 7:0; the word marked last carries 0 to 4 valid bytes. Words are written
// into the block at one per cycle while the engine is filling it; each full block
// then holds the engine for 64 compression steps on one shared round unit plus
// the chaining add, and a four-entry queue absorbs words arriving during a
// compression. The last word is followed by the padding words and one or two
// more compressions, after which the four digest words come out in order, word 0
// first, with digest_done on the fourth; the core then starts over for a new
// message.
module md5_hash_core_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_digest_done
);
    import md5_pkg::*;

    logic   push;
    logic   full;
    logic   pop;
    logic   q_valid;
    t_entry front_entry;
    t_entry q_entry;

    md5_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_message_word (i_message_word),
        .i_valid_bytes  (i_valid_bytes),
        .i_is_last      (i_is_last),
        .o_push         (push),
        .o_entry        (front_entry),
        .i_full         (full)
    );

    md5_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    md5_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_entry),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_digest_done (o_digest_done)
    );

endmodule

@@ verif/md5_digest_check_pkg.sv @@
`timescale 1ns / 1ps
// Expected-digest model and scoreboard for the MD5 hash core testbench.
// Self-contained: holds its own MD5 tables and does not depend on md5_pkg.
package md5_digest_check_pkg;

    localparam bit [31:0] MD5_IV_A = 32'h67452301;
    localparam bit [31:0] MD5_IV_B = 32'hefcdab89;
    localparam bit [31:0] MD5_IV_C = 32'h98badcfe;
    localparam bit [31:0] MD5_IV_D = 32'h10325476;
    localparam bit [7:0]  MD5_PAD_BYTE = 8'h80;
    localparam bit [5:0]  MD5_LENGTH_POS = 6'd56;
    localparam int        MD5_MAX_LAST_BYTES = 4;

    localparam bit [31:0] MD5_SINE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int unsigned MD5_SHIFT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct packed {
        bit [31:0] word;
        bit [1:0]  index;
        bit        done;
    } t_digest_word;

    class md5_digest_scoreboard;
        bit [31:0]    chain [4];
        bit [31:0]    block_words [16];
        bit [63:0]    msg_bits;
        bit [5:0]     byte_pos;
        t_digest_word digest_expected [$];
        int           errors;
        int           digests_checked;
        int           messages;
        int           words;

        function new();
            foreach (block_words[i]) block_words[i] = '0;
            errors = 0;
            digests_checked = 0;
            messages = 0;
            words = 0;
            restart_message();
        endfunction

        function void restart_message();
            chain[0] = MD5_IV_A;
            chain[1] = MD5_IV_B;
            chain[2] = MD5_IV_C;
            chain[3] = MD5_IV_D;
            msg_bits = '0;
            byte_pos = '0;
        endfunction

        function void compress_block();
            bit [31:0] a, b, c, d, f, sum, tmp;
            int unsigned g, rnd, s;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int i = 0; i < 64; i++) begin
                rnd = i / 16;
                case (rnd)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = i % 16;
                    end
                    1: begin
                        f = (b & d) | (c & ~d);
                        g = (5 * i + 1) % 16;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = (3 * i + 5) % 16;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = (7 * i) % 16;
                    end
                endcase
                s = MD5_SHIFT[rnd * 4 + i % 4];
                sum = a + f + MD5_SINE[i] + block_words[g];
                tmp = d;
                d = c;
                c = b;
                b = b + ((sum << s) | (sum >> (32 - s)));
                a = tmp;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void push_byte(bit [7:0] v);
            if (byte_pos[1:0] == 2'd0) begin
                block_words[byte_pos[5:2]] = {24'b0, v};
            end else begin
                block_words[byte_pos[5:2]] |= {24'b0, v} << {byte_pos[1:0], 3'b000};
            end
            byte_pos = byte_pos + 6'd1;
            if (byte_pos == 6'd0) begin
                compress_block();
            end
        endfunction

        // Called for every accepted request; the last word closes the message
        // and queues the four digest words it must produce.
        function void absorb_word(bit [31:0] word, bit [2:0] nbytes, bit last);
            int unsigned n;
            bit [63:0] total;
            words++;
            if (!last) begin
                for (int k = 0; k < 4; k++) push_byte(word[8 * k +: 8]);
                msg_bits += 64'd32;
                return;
            end
            n = (nbytes > MD5_MAX_LAST_BYTES) ? MD5_MAX_LAST_BYTES : nbytes;
            for (int k = 0; k < n; k++) push_byte(word[8 * k +: 8]);
            msg_bits += 64'(n * 8);
            total = msg_bits;
            push_byte(MD5_PAD_BYTE);
            while (byte_pos != MD5_LENGTH_POS) push_byte(8'h00);
            for (int k = 0; k < 8; k++) push_byte(total[8 * k +: 8]);
            for (int k = 0; k < 4; k++) begin
                digest_expected.push_back('{chain[k], 2'(k), k == 3});
            end
            messages++;
            restart_message();
        endfunction

        function void check_digest_word(bit [31:0] word, bit [1:0] index, bit done);
            t_digest_word exp_word;
            if (digest_expected.size() == 0) begin
                $display("%0t: unexpected digest word: expected none, actual %h index %0d",
                         $time, word, index);
                errors++;
                return;
            end
            exp_word = digest_expected.pop_front();
            digests_checked++;
            if (word !== exp_word.word) begin
                $display("%0t: digest_word mismatch: expected %h, actual %h",
                         $time, exp_word.word, word);
                errors++;
            end
            if (index !== exp_word.index) begin
                $display("%0t: word_index mismatch: expected %0d, actual %0d",
                         $time, exp_word.index, index);
                errors++;
            end
            if (done !== exp_word.done) begin
                $display("%0t: digest_done mismatch: expected %0d, actual %0d",
                         $time, exp_word.done, done);
                errors++;
            end
        endfunction
    endclass

endpackage

@@ verif/md5_hash_core_top_test.sv @@
`timescale 1ns / 1ps
// Testbench for md5_hash_core_top: directed and random messages with idle bursts.
// Depends on md5_digest_check_pkg and the RTL of md5_hash_core_top.
module md5_hash_core_top_test;
    import md5_digest_check_pkg::*;

    localparam int DIRECTED_WORDS = 23;
    localparam int RANDOM_WORDS   = 407;
    localparam int CALM_AFTER     = DIRECTED_WORDS + 360;
    localparam int DRAIN_CYCLES   = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_message_word;
    logic [2:0]  i_valid_bytes;
    logic        i_is_last;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [1:0]  o_word_index;
    logic        o_digest_done;

    md5_digest_scoreboard sb;
    int words_sent;
    bit calm;
    bit quiet;

    md5_hash_core_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_message_word (i_message_word),
        .i_valid_bytes  (i_valid_bytes),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_digest_done  (o_digest_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_500_000;
        $display("timeout: digest results did not drain");
        $display("tb: failure");
        $finish;
    end

    // Receiver side: random stall bursts, none while the run is quiet or once it turns calm.
    initial begin
        int stall_left;
        stall_left = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_stall = 1'b1;
            end else if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                i_stall = 1'b1;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_digest_word(o_digest_word, o_word_index, o_digest_done);
        end
    end

    task automatic send_request(input logic [31:0] word, input logic [2:0] nbytes,
                                input logic last);
        int gap;
        @(negedge i_clk);
        if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_message_word = word;
        i_valid_bytes = nbytes;
        i_is_last = last;
        do @(posedge i_clk); while (o_stall);
        sb.absorb_word(word, nbytes, last);
        words_sent++;
        if (words_sent >= CALM_AFTER) calm = 1'b1;
    endtask

    // Random content with the all-zero and all-one words mixed in; valid_bytes
    // is random on every word, including the ones where it must be ignored.
    task automatic send_message(input int nwords);
        logic [31:0] word;
        for (int k = 0; k < nwords; k++) begin
            case ($urandom_range(0, 7))
                0: word = 32'h0000_0000;
                1: word = 32'hffff_ffff;
                default: word = $urandom;
            endcase
            send_request(word, 3'($urandom_range(0, 7)), k == nwords - 1);
        end
    endtask

    initial begin
        int nwords;
        sb = new();
        words_sent = 0;
        calm = 1'b0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_message_word = '0;
        i_valid_bytes = '0;
        i_is_last = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty message first, with garbage in the dropped bytes.
        send_request(32'hffff_ffff, 3'd0, 1'b1);
        // Byte counts above four saturate.
        send_request(32'hffff_ffff, 3'd7, 1'b1);
        send_request(32'h0000_0000, 3'd5, 1'b1);
        send_request(32'h5a5a_a5a5, 3'd6, 1'b1);
        send_request($urandom, 3'd1, 1'b1);
        send_request($urandom, 3'd2, 1'b1);
        send_request($urandom, 3'd3, 1'b1);
        // A byte count on a non-last word is ignored.
        send_request(32'hffff_ffff, 3'd7, 1'b0);
        send_request(32'h0000_0000, 3'd4, 1'b1);
        // 56 message bytes: the padding spills into a second block.
        for (int k = 0; k < 13; k++) send_request($urandom, 3'd0, 1'b0);
        send_request($urandom, 3'd4, 1'b1);

        while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: nwords = $urandom_range(1, 8);
                6, 7: nwords = $urandom_range(9, 18);
                8: nwords = $urandom_range(14, 17);
                default: nwords = $urandom_range(17, 70);
            endcase
            // The final message is cut short so the run ends on the planned count.
            if (nwords > DIRECTED_WORDS + RANDOM_WORDS - words_sent) begin
                nwords = DIRECTED_WORDS + RANDOM_WORDS - words_sent;
            end
            send_message(nwords);
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.digest_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.digest_expected.size() != 0) begin
            $display("%0t: %0d digest words never arrived", $time, sb.digest_expected.size());
            sb.errors++;
        end
        $display("covered %0d messages in %0d words, %0d digest words compared",
                 sb.messages, sb.words, sb.digests_checked);
        $display("including empty, partial-byte, saturated and multi-block messages");
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
